/* hw/rtl/lorentz_velocity_push_defines.svh */
// Assertion macros used by the top-level RTL file.
`ifndef LORENTZ_VELOCITY_PUSH_DEFINES_SVH
`define LORENTZ_VELOCITY_PUSH_DEFINES_SVH
`ifndef SYNTHESIS
`define LVP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lorentz_velocity_push assertion failed");
`define LVP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lorentz_velocity_push assertion failed");
`else
`define LVP_ASSERT_IMP(lbl, ante, cons)
`define LVP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/lvp_pkg.sv */
package lvp_pkg;

  // Pipeline geometry.
  localparam int NSTG       = 16;
  localparam int DIV_STAGES = 8;
  localparam int DIV_BITS   = 4;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MASS   = 2'd1;
  localparam logic [1:0] ST_CHARGE = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_EFX = 3'd0;
  localparam logic [2:0] REG_EFY = 3'd1;
  localparam logic [2:0] REG_EFZ = 3'd2;
  localparam logic [2:0] REG_BFX = 3'd3;
  localparam logic [2:0] REG_BFY = 3'd4;
  localparam logic [2:0] REG_BFZ = 3'd5;
  localparam logic [2:0] REG_DT  = 3'd6;

  // Per-transaction data that travels alongside the arithmetic.
  typedef struct packed {
    logic [15:0]      tag;
    logic [2:0][31:0] vel;
    logic [31:0]      charge;
    logic [31:0]      mass;
    logic [1:0]       status;
  } side_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/lvp_if.sv */
// Particle input channel.
interface lvp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] particle_tag;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic [31:0] charge;
  logic [31:0] mass;
  modport source(output valid, particle_tag, vel_x, vel_y, vel_z, charge, mass, input ready);
  modport sink(input valid, particle_tag, vel_x, vel_y, vel_z, charge, mass, output ready);
endinterface

// Result output channel.
interface lvp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_tag;
  logic [31:0] new_vel_x;
  logic [31:0] new_vel_y;
  logic [31:0] new_vel_z;
  logic [1:0]  status;
  modport source(output valid, result_tag, new_vel_x, new_vel_y, new_vel_z, status,
                 input ready);
  modport sink(input valid, result_tag, new_vel_x, new_vel_y, new_vel_z, status,
               output ready);
endinterface

/* hw/rtl/lvp_force.sv */
module lvp_force (
  input  logic             clk,
  input  logic [2:0]       en,
  input  logic [2:0][31:0] vel,
  input  logic [31:0]      charge,
  input  logic [2:0][31:0] efield,
  input  logic [2:0][31:0] bfield,
  output logic [2:0][63:0] force_q
);
  import lvp_pkg::*;

  logic [2:0][63:0] pab;
  logic [2:0][63:0] pba;
  logic [2:0][31:0] sum;
  logic [2:0][31:0] sum_next;

  // Stage 1: the two cross product terms per axis.
  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      if (en[0]) begin
        pab[d] <= $signed(vel[(d + 1) % 3]) * $signed(bfield[(d + 2) % 3]);
        pba[d] <= $signed(vel[(d + 2) % 3]) * $signed(bfield[(d + 1) % 3]);
      end
    end
  end

  // Stage 2: difference, truncate toward zero to Q16.16, add E and saturate.
  always_comb begin
    logic signed [64:0] diff;
    logic signed [64:0] adj;
    logic signed [48:0] cross_q;
    for (int d = 0; d < 3; d++) begin
      diff = $signed({pab[d][63], pab[d]}) - $signed({pba[d][63], pba[d]});
      adj  = diff + (diff[64] ? 65'sd65535 : 65'sd0);
      cross_q = adj[64:16];
      sum_next[d] = sat32(66'($signed(efield[d])) + 66'(cross_q));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum <= sum_next;
    end
  end

  // Stage 3: charge times field sum, exact Q32.32.
  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      if (en[2]) begin
        force_q[d] <= $signed(charge) * $signed(sum[d]);
      end
    end
  end

endmodule

/* hw/rtl/lvp_div.sv */
module lvp_div (
  input  logic             clk,
  input  logic [9:0]       en,
  input  logic [2:0][63:0] force_q,
  input  logic [31:0]      mass,
  output logic [2:0][31:0] accel
);
  import lvp_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] quo;
  } div_t;

  // Restoring division, DIV_BITS quotient bits per stage.
  function automatic div_t div_iter(input div_t x, input logic [31:0] dvs);
    div_t        y;
    logic [31:0] r;
    y = x;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {y.rem[30:0], y.lo[31]};
      y.lo = {y.lo[30:0], 1'b0};
      if (r >= dvs) begin
        y.rem = r - dvs;
        y.quo = {y.quo[30:0], 1'b1};
      end else begin
        y.rem = r;
        y.quo = {y.quo[30:0], 1'b0};
      end
    end
    return y;
  endfunction

  div_t        dv  [DIV_STAGES+1][3];
  logic [2:0]  neg [DIV_STAGES+1];
  logic [2:0]  ovf [DIV_STAGES+1];
  logic [31:0] dvs [DIV_STAGES+1];

  // Stage 4: magnitude, sign and quotient overflow check.
  always_ff @(posedge clk) begin
    logic [63:0] mag;
    if (en[0]) begin
      dvs[0] <= mass;
      for (int d = 0; d < 3; d++) begin
        mag = force_q[d][63] ? (64'd0 - force_q[d]) : force_q[d];
        neg[0][d] <= force_q[d][63];
        ovf[0][d] <= (mag[63:32] >= mass);
        dv[0][d]  <= '{rem: mag[63:32], lo: mag[31:0], quo: 32'd0};
      end
    end
  end

  // Stages 5 to 12: division iterations.
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[j]) begin
        dvs[j] <= dvs[j-1];
        neg[j] <= neg[j-1];
        ovf[j] <= ovf[j-1];
        for (int d = 0; d < 3; d++) begin
          dv[j][d] <= div_iter(dv[j-1][d], dvs[j-1]);
        end
      end
    end
  end

  // Stage 13: apply sign and saturate the quotient.
  always_ff @(posedge clk) begin
    logic [31:0] q;
    if (en[DIV_STAGES+1]) begin
      for (int d = 0; d < 3; d++) begin
        q = dv[DIV_STAGES][d].quo;
        if (neg[DIV_STAGES][d]) begin
          accel[d] <= (ovf[DIV_STAGES][d] || q > 32'h8000_0000) ? 32'h8000_0000
                                                                : 32'd0 - q;
        end else begin
          accel[d] <= (ovf[DIV_STAGES][d] || q[31]) ? 32'h7FFF_FFFF : q;
        end
      end
    end
  end

endmodule

/* hw/rtl/lvp_update.sv */
module lvp_update (
  input  logic             clk,
  input  logic [1:0]       en,
  input  logic [2:0][31:0] accel,
  input  logic [31:0]      time_step,
  input  logic [2:0][31:0] vel,
  input  logic [1:0]       status,
  output logic [2:0][31:0] new_vel
);
  import lvp_pkg::*;

  logic [2:0][63:0] prod;
  logic [2:0][31:0] nv_next;

  // Stage 14: acceleration times the time step, Q16.48.
  always_ff @(posedge clk) begin
    logic signed [64:0] p;
    for (int d = 0; d < 3; d++) begin
      if (en[0]) begin
        p = $signed(accel[d]) * $signed({1'b0, time_step});
        prod[d] <= p[63:0];
      end
    end
  end

  // Stage 15: truncate toward zero, add to the velocity and saturate; skipped particles keep their velocity.
  always_comb begin
    logic signed [64:0] adj;
    logic signed [32:0] delta;
    for (int d = 0; d < 3; d++) begin
      adj = $signed({prod[d][63], prod[d]}) + (prod[d][63] ? 65'sh0_FFFF_FFFF : 65'sd0);
      delta = adj[64:32];
      if (status == ST_OK) begin
        nv_next[d] = sat32(66'($signed(vel[d])) + 66'(delta));
      end else begin
        nv_next[d] = vel[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      new_vel <= nv_next;
    end
  end

endmodule

/* hw/rtl/lorentz_velocity_push.sv */
// Lorentz velocity push: one explicit Euler step v + dt * q (E + v x B) / m.
// Particles arrive as transactions on the particle channel (valid/ready) and
// leave as transactions on the result channel, one result per particle, in
// order. Fields E, B and the time step are written through cfg_we, cfg_index
// and cfg_data; unknown indexes are ignored. The user must write them only
// while no particle is in flight; the block itself does not enforce this.
// Throughput: one particle per cycle unless a stalled receiver has filled the
// pipeline. The pipeline has 16 register stages: an input register, cross
// products, field sum, force, a divider of 10 stages (magnitude, eight that
// retire four quotient bits each, sign and saturation), the time step product
// and the final add.
// A stage takes new data whenever it is empty or its successor moves, so
// bubbles collapse and particles keep entering while a result waits.
// When the receiver stalls, the pipeline fills and then particle.ready falls.
// Synchronous reset empties all stages and clears the field registers.
// Status 1 marks a nonpositive mass, status 2 a zero charge; in both cases
// the velocity passes through unchanged.
`include "lorentz_velocity_push_defines.svh"
module lorentz_velocity_push (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  lvp_in_if.sink        particle,
  lvp_out_if.source     result
);
  import lvp_pkg::*;

  logic [2:0][31:0] efield;
  logic [2:0][31:0] bfield;
  logic [31:0]      time_step;

  logic [NSTG-1:0]  vld;
  logic [NSTG-1:0]  en;
  side_t            side [NSTG];
  side_t            side_in;

  logic [2:0][63:0] force_q;
  logic [2:0][31:0] accel;
  logic [2:0][31:0] new_vel;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      efield    <= '0;
      bfield    <= '0;
      time_step <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EFX: efield[0]  <= cfg_data;
        REG_EFY: efield[1]  <= cfg_data;
        REG_EFZ: efield[2]  <= cfg_data;
        REG_BFX: bfield[0]  <= cfg_data;
        REG_BFY: bfield[1]  <= cfg_data;
        REG_BFZ: bfield[2]  <= cfg_data;
        REG_DT:  time_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor moves.
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || result.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= particle.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Entry decode of the special cases.
  always_comb begin
    side_in.tag    = particle.particle_tag;
    side_in.vel    = {particle.vel_z, particle.vel_y, particle.vel_x};
    side_in.charge = particle.charge;
    side_in.mass   = particle.mass;
    priority if ($signed(particle.mass) <= 0) begin
      side_in.status = ST_MASS;
    end else if (particle.charge == '0) begin
      side_in.status = ST_CHARGE;
    end else begin
      side_in.status = ST_OK;
    end
  end

  // Sideband travels with the valid bits.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      side[0] <= side_in;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign particle.ready = en[0];

  lvp_force u_force (
    .clk     (clk),
    .en      (en[3:1]),
    .vel     (side[0].vel),
    .charge  (side[2].charge),
    .efield  (efield),
    .bfield  (bfield),
    .force_q (force_q)
  );

  lvp_div u_div (
    .clk     (clk),
    .en      (en[13:4]),
    .force_q (force_q),
    .mass    (side[3].mass),
    .accel   (accel)
  );

  lvp_update u_update (
    .clk       (clk),
    .en        (en[15:14]),
    .accel     (accel),
    .time_step (time_step),
    .vel       (side[14].vel),
    .status    (side[14].status),
    .new_vel   (new_vel)
  );

  // Result channel.
  assign result.valid      = vld[NSTG-1];
  assign result.result_tag = side[NSTG-1].tag;
  assign result.new_vel_x  = new_vel[0];
  assign result.new_vel_y  = new_vel[1];
  assign result.new_vel_z  = new_vel[2];
  assign result.status     = side[NSTG-1].status;

  // Input is held off only when every stage is occupied.
  `LVP_ASSERT_IMP(a_full_when_blocked, !en[0], &vld)
  // A particle with nonpositive mass enters marked as skipped.
  `LVP_ASSERT_NEXT(a_mass_skip, particle.valid && en[0] && $signed(particle.mass) <= 0, vld[0] && side[0].status == ST_MASS)
  // Skipped particles leave with their velocity untouched.
  `LVP_ASSERT_IMP(a_skip_pass, vld[NSTG-1] && side[NSTG-1].status != ST_OK, new_vel == side[NSTG-1].vel)

endmodule

/* verif/lorentz_velocity_push_tb.sv */
module lorentz_velocity_push_tb;
  import lvp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_RAND    = 400;
  localparam int NUM_PHASES  = 5;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] charge;
    logic [31:0] mass;
  } particle_t;

  typedef struct packed {
    logic [15:0]      tag;
    logic [2:0][31:0] vel;
    logic [1:0]       status;
  } push_result_t;

  typedef struct packed {
    particle_t    p;
    logic         typed;
    push_result_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  lvp_in_if  pin();
  lvp_out_if pout();

  lorentz_velocity_push uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .particle  (pin),
    .result    (pout)
  );

  // Local copy of the field and time step registers.
  logic signed [31:0] efield [3];
  logic signed [31:0] bfield [3];
  logic [31:0]        dt_reg;

  push_result_t pending_q[$];
  int errors;
  int cycles;
  int n_ok, n_mass, n_charge;
  bit recv_busy_mode;
  int recv_stall;

  // Clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic wide_t sat_s32(wide_t x);
    if (x > 128'sd2147483647) return 128'sd2147483647;
    if (x < -128'sd2147483648) return -128'sd2147483648;
    return x;
  endfunction

  // Arithmetic shift that rounds toward zero.
  function automatic wide_t shift_toward_zero(wide_t x, int n);
    wide_t mag;
    if (x < 0) begin
      mag = -x;
      return -(mag >> n);
    end
    return x >> n;
  endfunction

  // One explicit Euler velocity step under the current fields.
  function automatic push_result_t push_velocity(particle_t p);
    push_result_t r;
    wide_t v [3];
    wide_t q, m, cross_term, sum, force_val, accel, delta, dtw;
    int a, b;
    v[0] = signed'(p.vx);
    v[1] = signed'(p.vy);
    v[2] = signed'(p.vz);
    q = signed'(p.charge);
    m = signed'(p.mass);
    dtw = {96'd0, dt_reg};
    r.tag = p.tag;
    for (int d = 0; d < 3; d++) r.vel[d] = v[d][31:0];
    if (m <= 0) begin
      r.status = ST_MASS;
    end else if (q == 0) begin
      r.status = ST_CHARGE;
    end else begin
      r.status = ST_OK;
      for (int d = 0; d < 3; d++) begin
        a = (d + 1) % 3;
        b = (d + 2) % 3;
        cross_term = shift_toward_zero(v[a] * wide_t'(bfield[b]) - v[b] * wide_t'(bfield[a]),
                                       16);
        sum = sat_s32(wide_t'(efield[d]) + cross_term);
        force_val = q * sum;
        accel = sat_s32(force_val / m);
        delta = shift_toward_zero(accel * dtw, 32);
        r.vel[d] = sat_s32(v[d] + delta);
      end
    end
    return r;
  endfunction

  // Register write; the local copy follows the same index decode.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_EFX, REG_EFY, REG_EFZ: begin
        efield[idx] = val;
      end
      REG_BFX, REG_BFY, REG_BFZ: begin
        bfield[idx - REG_BFX] = val;
      end
      REG_DT: begin
        dt_reg = val;
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_fields(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                            logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                            logic [31:0] dt);
    write_reg(REG_EFX, ex);
    write_reg(REG_EFY, ey);
    write_reg(REG_EFZ, ez);
    write_reg(REG_BFX, bx);
    write_reg(REG_BFY, by);
    write_reg(REG_BFZ, bz);
    write_reg(REG_DT, dt);
    // Index 7 decodes to nothing and must leave the fields alone.
    write_reg(3'd7, $urandom);
    cfg_we <= 1'b0;
  endtask

  // Hold the particle channel idle until every result is back.
  task automatic drain();
    pin.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Offer one particle and wait for the transaction.
  task automatic send_particle(particle_t p, bit typed, push_result_t want, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      pin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin.valid        <= 1'b1;
    pin.particle_tag <= p.tag;
    pin.vel_x        <= p.vx;
    pin.vel_y        <= p.vy;
    pin.vel_z        <= p.vz;
    pin.charge       <= p.charge;
    pin.mass         <= p.mass;
    do @(posedge clk); while (!pin.ready);
    pending_q.push_back(typed ? want : push_velocity(p));
  endtask

  function automatic logic [31:0] rand_q16(bit tiny);
    return tiny ? 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000) : $urandom;
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    int kind;
    bit tiny;
    kind = $urandom_range(0, 11);
    tiny = $urandom_range(0, 1);
    p.tag = $urandom;
    p.vx = rand_q16(tiny);
    p.vy = rand_q16(tiny);
    p.vz = rand_q16(tiny);
    p.charge = ($urandom_range(0, 1)) ? rand_q16(1'b1) : $urandom;
    if (p.charge == 0) p.charge = 32'h0001_0000;
    p.mass = ($urandom_range(0, 1)) ? $urandom_range(1, 32'h0010_0000) : $urandom_range(1, 32'h7FFF_FFFF);
    case (kind)
      0: p.mass = ($urandom_range(0, 3) == 0) ? 32'd0 : (32'h8000_0000 | $urandom);
      1: p.charge = 32'd0;
      default: begin
      end
    endcase
    return p;
  endfunction

  // Result side: random back-pressure and in-order checking.
  always @(posedge clk) begin
    push_result_t exp_r;
    int stall_draw;
    cycles <= cycles + 1;
    if (rst) begin
      pout.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (pout.valid && pout.ready) begin
        if (pending_q.size() == 0) begin
          $error("result transaction with nothing pending, tag %h", pout.result_tag);
          errors++;
        end else begin
          exp_r = pending_q.pop_front();
          if (pout.result_tag !== exp_r.tag) begin
            $error("result_tag expected %h actual %h", exp_r.tag, pout.result_tag);
            errors++;
          end
          if (pout.new_vel_x !== exp_r.vel[0]) begin
            $error("new_vel_x expected %h actual %h", exp_r.vel[0], pout.new_vel_x);
            errors++;
          end
          if (pout.new_vel_y !== exp_r.vel[1]) begin
            $error("new_vel_y expected %h actual %h", exp_r.vel[1], pout.new_vel_y);
            errors++;
          end
          if (pout.new_vel_z !== exp_r.vel[2]) begin
            $error("new_vel_z expected %h actual %h", exp_r.vel[2], pout.new_vel_z);
            errors++;
          end
          if (pout.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, pout.status);
            errors++;
          end
          case (exp_r.status)
            ST_MASS:   n_mass++;
            ST_CHARGE: n_charge++;
            default:   n_ok++;
          endcase
        end
      end
      // After each taken result outside busy mode, a random draw decides how long ready stays low before the next.
      if (recv_stall > 0) begin
        pout.ready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (pout.ready && !recv_busy_mode && pout.valid) begin
        stall_draw = $urandom_range(0, 6);
        pout.ready <= (stall_draw == 0);
        recv_stall <= (stall_draw == 0) ? 0 : stall_draw - 1;
      end else begin
        pout.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [12];
    push_result_t none;
    particle_t p;
    bit no_gap;
    none = '0;
    errors = 0;
    cycles = 0;
    n_ok = 0;
    n_mass = 0;
    n_charge = 0;
    recv_busy_mode = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pin.valid = 1'b0;
    pin.particle_tag = '0;
    pin.vel_x = '0;
    pin.vel_y = '0;
    pin.vel_z = '0;
    pin.charge = '0;
    pin.mass = '0;
    pout.ready = 1'b0;
    for (int d = 0; d < 3; d++) begin
      efield[d] = '0;
      bfield[d] = '0;
    end
    dt_reg = '0;

    // Directed rows; the first six have results that follow directly from the
    // skip rules or from the all-zero fields after reset.
    rows[0]  = '{'{16'h0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
                 '{16'h0000, {32'h0, 32'h0, 32'h0}, ST_MASS}};
    rows[1]  = '{'{16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000}, 1'b1,
                 '{16'hFFFF, {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, ST_MASS}};
    rows[2]  = '{'{16'h1234, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1,
                   32'hFFFF_FFFF}, 1'b1,
                 '{16'h1234, {32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, ST_MASS}};
    rows[3]  = '{'{16'h0001, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, 32'h0, 32'h1},
                 1'b1,
                 '{16'h0001, {32'h5555_5555, 32'hFFFF_0000, 32'h0001_0000}, ST_CHARGE}};
    rows[4]  = '{'{16'hAAAA, 32'hAAAA_AAAA, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                   32'h7FFF_FFFF}, 1'b1,
                 '{16'hAAAA, {32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA}, ST_CHARGE}};
    rows[5]  = '{'{16'h5555, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h1, 32'h1}, 1'b1,
                 '{16'h5555, {32'h0, 32'h8765_4321, 32'h1234_5678}, ST_OK}};
    rows[6]  = '{'{16'h0100, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h1}, 1'b0, none};
    rows[7]  = '{'{16'h0200, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h1}, 1'b0, none};
    rows[8]  = '{'{16'h0300, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'h7FFF_FFFF},
                 1'b0, none};
    rows[9]  = '{'{16'h0400, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h1}, 1'b0, none};
    rows[10] = '{'{16'h0500, 32'h0002_8000, 32'hFFFD_0000, 32'h0000_4000, 32'hFFFF_FFFF,
                   32'h0001_0000}, 1'b0, none};
    rows[11] = '{'{16'h0600, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                   32'h0001_0000}, 1'b0, none};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass under the reset fields.
    foreach (rows[i]) send_particle(rows[i].p, rows[i].typed, rows[i].want, 1'b0);
    drain();

    // Same rows under extreme fields and the largest time step.
    set_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    foreach (rows[i]) send_particle(rows[i].p, 1'b0, none, 1'b0);
    drain();

    // Random phases, each under its own field setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_fields($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: set_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
        2: set_fields(rand_q16(1'b1), rand_q16(1'b1), rand_q16(1'b1),
                      rand_q16(1'b1), rand_q16(1'b1), rand_q16(1'b1),
                      $urandom_range(0, 32'h1000_0000));
        3: set_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1);
        default: set_fields(rand_q16(1'b1), $urandom, rand_q16(1'b1),
                            $urandom, rand_q16(1'b1), $urandom, $urandom);
      endcase
      for (int k = 0; k < NUM_RAND / NUM_PHASES; k++) begin
        // Alternate stretches of full-rate traffic with randomly gapped traffic.
        if (k % 20 == 0) recv_busy_mode = $urandom_range(0, 2) == 0;
        no_gap = recv_busy_mode;
        p = rand_particle();
        send_particle(p, 1'b0, none, no_gap);
        if (ph == 2 && k == 40) drain();
      end
      recv_busy_mode = 1'b0;
      drain();
    end

    pin.valid <= 1'b0;
    $display("Covered %0d updated, %0d mass-skipped and %0d charge-skipped particles",
             n_ok, n_mass, n_charge);
    $display("over reset, extreme, small and random field settings with random stalls.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/lvp_pkg.sv
hw/rtl/lvp_if.sv
hw/rtl/lvp_force.sv
hw/rtl/lvp_div.sv
hw/rtl/lvp_update.sv
hw/rtl/lorentz_velocity_push.sv
verif/lorentz_velocity_push_tb.sv
